// File: sv/sorp_pkg.sv
package sorp_pkg;

    // Screen and geometry
    localparam int SCREEN_W    = 640;
    localparam int SCREEN_H    = 480;
    localparam int MAX_LENGTH  = 1024;
    localparam int FOCAL       = 200;
    localparam int FOCAL_Q8    = 200 * 256;
    localparam int CENTER_Z_Q8 = 300 * 256;
    localparam int Y_INIT_Q8   = 256;

    // Word widths
    localparam int LEN_W    = 11;
    localparam int CFG_W    = 16;
    localparam int SIDE_W   = 2;
    localparam int STEP_W   = 10;
    localparam int SCR_W    = 16;
    localparam int IDX_W    = 3;
    localparam int COORD_W  = 28;              // Q.8 coordinates, three rotations of headroom
    localparam int SIN_W    = CFG_W + 1;       // room for a negated sine
    localparam int PROD_W   = COORD_W + SIN_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int NUM_W    = 35;              // |x * 200| magnitude
    localparam int DEN_W    = 28;              // z + 200 in Q.8, positive

    localparam int Q_FRAC_SHIFT = 14;
    localparam int ROUND_BIAS   = 8192;

    // Pipeline depths
    localparam int ROT_LAT  = 2;
    localparam int DIV_LAT  = NUM_W;
    localparam int PIPE_LAT = 3 * ROT_LAT + 1 + DIV_LAT;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_PLANE_LENGTH = 3'd0,
        REG_SIN_X        = 3'd1,
        REG_COS_X        = 3'd2,
        REG_SIN_Y        = 3'd3,
        REG_COS_Y        = 3'd4,
        REG_SIN_Z        = 3'd5,
        REG_COS_Z        = 3'd6
    } t_reg_idx;

    typedef enum logic [SIDE_W-1:0] {
        SIDE_FRONT = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_BACK  = 2'd2,
        SIDE_RIGHT = 2'd3
    } t_side;

    typedef struct packed {
        logic        [LEN_W-1:0] plane_length;
        logic signed [CFG_W-1:0] sin_x;
        logic signed [CFG_W-1:0] cos_x;
        logic signed [CFG_W-1:0] sin_y;
        logic signed [CFG_W-1:0] cos_y;
        logic signed [CFG_W-1:0] sin_z;
        logic signed [CFG_W-1:0] cos_z;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic vis;
        logic neg_x;
        logic neg_y;
    } t_tag;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic             qbit;
    } t_div_step;

    // One restoring division step
    function automatic t_div_step div_step(input logic [DEN_W-1:0] rem,
                                           input logic nbit,
                                           input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        t_div_step      r;
        t = {rem, nbit};
        if (t >= {1'b0, den}) begin
            r.rem  = DEN_W'(t - {1'b0, den});
            r.qbit = 1'b1;
        end else begin
            r.rem  = t[DEN_W-1:0];
            r.qbit = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [SCR_W-1:0] sat16(input logic signed [NUM_W+1:0] v);
        logic signed [NUM_W+1:0] hi;
        logic signed [NUM_W+1:0] lo;
        hi = (NUM_W+2)'(32767);
        lo = -(NUM_W+2)'(32768);
        if (v > hi) begin
            return SCR_W'(32767);
        end else if (v < lo) begin
            return SCR_W'(-32768);
        end
        return v[SCR_W-1:0];
    endfunction

endpackage

// File: sv/sorp_front.sv
module sorp_front import sorp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [SIDE_W-1:0]  i_edge_side,
    input  logic [STEP_W-1:0]  i_edge_step,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output t_cfg               o_cfg,
    output t_point             o_pt,
    output logic               o_pt_valid,
    input  logic               i_take
);

    t_cfg                      r_cfg;
    t_point                    r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         r_wr;
    logic [QPTR_W-1:0]         r_rd;
    logic [QPTR_W:0]           r_cnt;
    logic                      push_ok;
    logic                      pop_ok;
    logic [LEN_W-1:0]          len;
    logic signed [COORD_W-1:0] half;
    logic signed [COORD_W-1:0] run;
    t_point                    pt;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plane_length <= LEN_W'(100);
            r_cfg.sin_x        <= '0;
            r_cfg.cos_x        <= CFG_W'(16384);
            r_cfg.sin_y        <= '0;
            r_cfg.cos_y        <= CFG_W'(16384);
            r_cfg.sin_z        <= '0;
            r_cfg.cos_z        <= CFG_W'(16384);
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PLANE_LENGTH: r_cfg.plane_length <= i_cfg_data[LEN_W-1:0];
                REG_SIN_X:        r_cfg.sin_x        <= i_cfg_data;
                REG_COS_X:        r_cfg.cos_x        <= i_cfg_data;
                REG_SIN_Y:        r_cfg.sin_y        <= i_cfg_data;
                REG_COS_Y:        r_cfg.cos_y        <= i_cfg_data;
                REG_SIN_Z:        r_cfg.sin_z        <= i_cfg_data;
                REG_COS_Z:        r_cfg.cos_z        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Place the point on the square outline
    always_comb begin
        len  = (r_cfg.plane_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                          : r_cfg.plane_length;
        half = COORD_W'({len, 7'd0});
        run  = COORD_W'({i_edge_step, 8'd0}) - half;
        unique case (t_side'(i_edge_side))
            SIDE_FRONT: begin pt.x = run;   pt.z = half;  end
            SIDE_LEFT:  begin pt.x = -half; pt.z = run;   end
            SIDE_BACK:  begin pt.x = run;   pt.z = -half; end
            SIDE_RIGHT: begin pt.x = half;  pt.z = run;   end
            default:    begin pt.x = half;  pt.z = run;   end
        endcase
        pt.z = pt.z + COORD_W'(CENTER_Z_Q8);
    end

    assign o_full     = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_pt_valid = (r_cnt != '0);
    assign o_pt       = r_q[r_rd];
    assign push_ok    = i_push && !o_full;
    assign pop_ok     = i_take && o_pt_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(pop_ok);
        end
    end

endmodule

// File: sv/sorp_rotate.sv
module sorp_rotate import sorp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [COORD_W-1:0] i_a,
    input  logic signed [COORD_W-1:0] i_b,
    input  logic signed [COORD_W-1:0] i_p,
    input  logic signed [CFG_W-1:0]   i_c,
    input  logic signed [SIN_W-1:0]   i_s,
    output logic signed [COORD_W-1:0] o_a,
    output logic signed [COORD_W-1:0] o_b,
    output logic signed [COORD_W-1:0] o_p
);

    logic signed [PROD_W-1:0]  r_ac, r_bs, r_as, r_bc;
    logic signed [COORD_W-1:0] r_p1, r_a, r_b, r_p2;
    logic signed [SUM_W-1:0]   sum_a, sum_b;

    // a' = a*c - b*s, b' = a*s + b*c, rounded half up to Q.8
    assign sum_a = SUM_W'(r_ac) - SUM_W'(r_bs) + SUM_W'(ROUND_BIAS);
    assign sum_b = SUM_W'(r_as) + SUM_W'(r_bc) + SUM_W'(ROUND_BIAS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ac <= PROD_W'(i_a) * PROD_W'(i_c);
            r_bs <= PROD_W'(i_b) * PROD_W'(i_s);
            r_as <= PROD_W'(i_a) * PROD_W'(i_s);
            r_bc <= PROD_W'(i_b) * PROD_W'(i_c);
            r_p1 <= i_p;
            r_a  <= COORD_W'(sum_a >>> Q_FRAC_SHIFT);
            r_b  <= COORD_W'(sum_b >>> Q_FRAC_SHIFT);
            r_p2 <= r_p1;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_p = r_p2;

endmodule

// File: sv/sorp_divide.sv
module sorp_divide import sorp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [NUM_W-1:0]   i_num_x,
    input  logic [NUM_W-1:0]   i_num_y,
    input  logic [DEN_W-1:0]   i_den,
    input  t_tag               i_tag,
    output logic [NUM_W-1:0]   o_q_x,
    output logic [NUM_W-1:0]   o_q_y,
    output t_tag               o_tag
);

    logic [DEN_W-1:0] r_rem_x [DIV_LAT];
    logic [DEN_W-1:0] r_rem_y [DIV_LAT];
    logic [NUM_W-1:0] r_num_x [DIV_LAT];
    logic [NUM_W-1:0] r_num_y [DIV_LAT];
    logic [NUM_W-1:0] r_q_x   [DIV_LAT];
    logic [NUM_W-1:0] r_q_y   [DIV_LAT];
    logic [DEN_W-1:0] r_den   [DIV_LAT];
    t_tag             r_tag   [DIV_LAT];

    logic [DEN_W-1:0] p_rem_x [DIV_LAT];
    logic [DEN_W-1:0] p_rem_y [DIV_LAT];
    logic [NUM_W-1:0] p_num_x [DIV_LAT];
    logic [NUM_W-1:0] p_num_y [DIV_LAT];
    logic [NUM_W-1:0] p_q_x   [DIV_LAT];
    logic [NUM_W-1:0] p_q_y   [DIV_LAT];
    logic [DEN_W-1:0] p_den   [DIV_LAT];
    t_tag             p_tag   [DIV_LAT];
    t_div_step        s_x     [DIV_LAT];
    t_div_step        s_y     [DIV_LAT];

    // One quotient bit per stage, most significant first
    always_comb begin
        for (int k = 0; k < DIV_LAT; k++) begin
            if (k == 0) begin
                p_rem_x[k] = '0;
                p_rem_y[k] = '0;
                p_num_x[k] = i_num_x;
                p_num_y[k] = i_num_y;
                p_q_x[k]   = '0;
                p_q_y[k]   = '0;
                p_den[k]   = i_den;
                p_tag[k]   = i_tag;
            end else begin
                p_rem_x[k] = r_rem_x[k-1];
                p_rem_y[k] = r_rem_y[k-1];
                p_num_x[k] = r_num_x[k-1];
                p_num_y[k] = r_num_y[k-1];
                p_q_x[k]   = r_q_x[k-1];
                p_q_y[k]   = r_q_y[k-1];
                p_den[k]   = r_den[k-1];
                p_tag[k]   = r_tag[k-1];
            end
            s_x[k] = div_step(p_rem_x[k], p_num_x[k][NUM_W-1], p_den[k]);
            s_y[k] = div_step(p_rem_y[k], p_num_y[k][NUM_W-1], p_den[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_rem_x[k] <= s_x[k].rem;
                r_rem_y[k] <= s_y[k].rem;
                r_num_x[k] <= {p_num_x[k][NUM_W-2:0], 1'b0};
                r_num_y[k] <= {p_num_y[k][NUM_W-2:0], 1'b0};
                r_q_x[k]   <= {p_q_x[k][NUM_W-2:0], s_x[k].qbit};
                r_q_y[k]   <= {p_q_y[k][NUM_W-2:0], s_y[k].qbit};
                r_den[k]   <= p_den[k];
                r_tag[k]   <= p_tag[k];
            end
        end
    end

    assign o_q_x = r_q_x[DIV_LAT-1];
    assign o_q_y = r_q_y[DIV_LAT-1];
    assign o_tag = r_tag[DIV_LAT-1];

endmodule

// File: sv/sorp_back.sv
module sorp_back import sorp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_point                  i_pt,
    input  logic                    i_pt_valid,
    output logic                    o_take,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic signed [SCR_W-1:0] o_pix_x,
    output logic signed [SCR_W-1:0] o_pix_y,
    output logic                    o_visible
);

    logic                      en;
    logic [PIPE_LAT-1:0]       r_vld;
    logic signed [COORD_W-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
    logic signed [COORD_W:0]   den_s;
    logic signed [NUM_W:0]     prod_x, prod_y;
    logic [NUM_W-1:0]          r_num_x, r_num_y;
    logic [DEN_W-1:0]          r_den;
    t_tag                      r_tag, d_tag;
    logic [NUM_W-1:0]          q_x, q_y;
    logic signed [NUM_W+1:0]   sx, sy;
    logic                      r_out_valid;
    logic signed [SCR_W-1:0]   r_out_x, r_out_y;
    logic                      r_out_vis;

    // Whole pipeline advances while the output register can take a beat
    assign en     = !r_out_valid || i_pop;
    assign o_take = en && i_pt_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], o_take};
        end
    end

    sorp_rotate u_rot_x (
        .i_clk (i_clk), .i_en (en),
        .i_a (COORD_W'(Y_INIT_Q8)), .i_b (i_pt.z), .i_p (i_pt.x),
        .i_c (i_cfg.cos_x), .i_s (SIN_W'(i_cfg.sin_x)),
        .o_a (y1), .o_b (z1), .o_p (x1)
    );

    sorp_rotate u_rot_z (
        .i_clk (i_clk), .i_en (en),
        .i_a (x1), .i_b (y1), .i_p (z1),
        .i_c (i_cfg.cos_z), .i_s (SIN_W'(i_cfg.sin_z)),
        .o_a (x2), .o_b (y2), .o_p (z2)
    );

    sorp_rotate u_rot_y (
        .i_clk (i_clk), .i_en (en),
        .i_a (x2), .i_b (z2), .i_p (y2),
        .i_c (i_cfg.cos_y), .i_s (-SIN_W'(i_cfg.sin_y)),
        .o_a (x3), .o_b (z3), .o_p (y3)
    );

    // Projection setup: depth term and numerator magnitudes
    always_comb begin
        den_s  = (COORD_W+1)'(z3) + (COORD_W+1)'(FOCAL_Q8);
        prod_x = (NUM_W+1)'(x3) * (NUM_W+1)'(FOCAL);
        prod_y = -((NUM_W+1)'(y3) * (NUM_W+1)'(FOCAL));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag.vis   <= (den_s > 0);
            r_tag.neg_x <= prod_x[NUM_W];
            r_tag.neg_y <= prod_y[NUM_W];
            r_num_x     <= prod_x[NUM_W] ? NUM_W'(-prod_x) : NUM_W'(prod_x);
            r_num_y     <= prod_y[NUM_W] ? NUM_W'(-prod_y) : NUM_W'(prod_y);
            r_den       <= (den_s > 0) ? DEN_W'(den_s) : DEN_W'(1);
        end
    end

    sorp_divide u_div (
        .i_clk (i_clk), .i_en (en),
        .i_num_x (r_num_x), .i_num_y (r_num_y), .i_den (r_den), .i_tag (r_tag),
        .o_q_x (q_x), .o_q_y (q_y), .o_tag (d_tag)
    );

    // Restore sign (truncation toward zero) and center; saturation is in the output register
    always_comb begin
        sx = (NUM_W+2)'(q_x);
        sy = (NUM_W+2)'(q_y);
        if (d_tag.neg_x) begin
            sx = -sx;
        end
        if (d_tag.neg_y) begin
            sy = -sy;
        end
        sx = sx + (NUM_W+2)'(SCREEN_W / 2);
        sy = sy + (NUM_W+2)'(SCREEN_H / 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_vis <= d_tag.vis;
            r_out_x   <= d_tag.vis ? sat16(sx) : '0;
            r_out_y   <= d_tag.vis ? sat16(sy) : '0;
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_pix_x   = r_out_x;
    assign o_pix_y   = r_out_y;
    assign o_visible = r_out_vis;

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_vis) |-> (r_out_x == '0 && r_out_y == '0))
        else $error("hidden point with nonzero coordinates");

    a_take_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (!r_out_valid || i_pop))
        else $error("queue popped while pipeline stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_vld)))
        else $error("pipeline moved during output stall");

endmodule

// File: sv/square_outline_rotate_project_top.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------
// point in  | i_push / o_full      | i_edge_side, i_edge_step
// result    | o_empty / i_pop      | o_pix_x, o_pix_y, o_visible
// config    | i_cfg_valid / ready  | i_cfg_index, i_cfg_data
//
// One point per cycle sustained while results are popped; a point passes through the
// input queue, three rotations of two stages each, projection setup, a 35-stage
// restoring divider (one quotient bit per stage) and the output register.
// Reset (i_rst_n low, synchronous) empties the queues and loads register defaults.
// A stalled result holds the whole back pipeline; the 4-beat input queue then
// fills and raises o_full. Config writes are always accepted (o_cfg_ready is tied high).
module square_outline_rotate_project_top import sorp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [SIDE_W-1:0]       i_edge_side,
    input  logic [STEP_W-1:0]       i_edge_step,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic signed [SCR_W-1:0] o_pix_x,
    output logic signed [SCR_W-1:0] o_pix_y,
    output logic                    o_visible,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    t_cfg   cfg;
    t_point pt;
    logic   pt_valid;
    logic   take;

    // Front: register file, side decode, point queue
    sorp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_edge_side (i_edge_side),
        .i_edge_step (i_edge_step),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_pt        (pt),
        .o_pt_valid  (pt_valid),
        .i_take      (take)
    );

    // Back: rotate, project, hold result
    sorp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_pt       (pt),
        .i_pt_valid (pt_valid),
        .o_take     (take),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_pix_x    (o_pix_x),
        .o_pix_y    (o_pix_y),
        .o_visible  (o_visible)
    );

endmodule

// File: verif/tb_square_outline_rotate_project_top.sv
module tb_square_outline_rotate_project_top;
    import sorp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run guard in clock cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Index past the last register: a write there must change nothing.
    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        logic signed [SCR_W-1:0] sx;
        logic signed [SCR_W-1:0] sy;
        logic                    vis;
    } t_pixel;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_push;
    logic                    o_full;
    logic [SIDE_W-1:0]       i_edge_side;
    logic [STEP_W-1:0]       i_edge_step;
    logic                    o_empty;
    logic                    i_pop;
    logic signed [SCR_W-1:0] o_pix_x;
    logic signed [SCR_W-1:0] o_pix_y;
    logic                    o_visible;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [IDX_W-1:0]        i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;

    square_outline_rotate_project_top DUT (.*);

    // Shadow copy of the configuration registers.
    longint shadow_len;
    longint shadow_sx, shadow_cx, shadow_sy, shadow_cy, shadow_sz, shadow_cz;

    t_pixel      pending_pixels[$];
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned beats_sent;
    int unsigned beats_checked;
    int unsigned hidden_seen;
    int unsigned cfg_writes;
    // Gap control for the point sender and the result receiver (pop_hold_cycles: receiver only).
    bit          burst_mode;
    int unsigned pop_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Round a Q.22 sum to Q.8: nearest, ties toward +infinity.
    function automatic longint round_q22(input longint v);
        return (v + ROUND_BIAS) >>> Q_FRAC_SHIFT;
    endfunction

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Expected screen position of one outline point under the shadow registers.
    function automatic t_pixel project_point(input logic [SIDE_W-1:0] side,
                                             input logic [STEP_W-1:0] step);
        longint len, half, run, x, y, z, a, b, den;
        t_pixel p;
        len  = (shadow_len > MAX_LENGTH) ? MAX_LENGTH : shadow_len;
        half = len * 128;
        run  = longint'(step) * 256 - half;
        case (t_side'(side))
            SIDE_FRONT: begin x = run;   z = half;  end
            SIDE_LEFT:  begin x = -half; z = run;   end
            SIDE_BACK:  begin x = run;   z = -half; end
            default:    begin x = half;  z = run;   end
        endcase
        y = Y_INIT_Q8;
        z = z + CENTER_Z_Q8;
        // rotate about X, then Z, then Y
        a = round_q22(y * shadow_cx - z * shadow_sx);
        b = round_q22(y * shadow_sx + z * shadow_cx);
        y = a; z = b;
        a = round_q22(x * shadow_cz - y * shadow_sz);
        b = round_q22(x * shadow_sz + y * shadow_cz);
        x = a; y = b;
        a = round_q22(x * shadow_cy + z * shadow_sy);
        b = round_q22(-x * shadow_sy + z * shadow_cy);
        x = a; z = b;
        den = z + FOCAL_Q8;
        if (den <= 0) begin
            p.sx = '0; p.sy = '0; p.vis = 1'b0;
        end else begin
            p.sx  = SCR_W'(clip16((x * FOCAL) / den + SCREEN_W / 2));
            p.sy  = SCR_W'(clip16((-y * FOCAL) / den + SCREEN_H / 2));
            p.vis = 1'b1;
        end
        return p;
    endfunction

    function automatic void shadow_write(input logic [IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
        case (idx)
            REG_PLANE_LENGTH: shadow_len = longint'(data[LEN_W-1:0]);
            REG_SIN_X:        shadow_sx  = longint'($signed(data));
            REG_COS_X:        shadow_cx  = longint'($signed(data));
            REG_SIN_Y:        shadow_sy  = longint'($signed(data));
            REG_COS_Y:        shadow_cy  = longint'($signed(data));
            REG_SIN_Z:        shadow_sz  = longint'($signed(data));
            REG_COS_Z:        shadow_cz  = longint'($signed(data));
            default:          ;
        endcase
    endfunction

    // Offer one point; hold it until the block takes the beat.
    task automatic send_point(input logic [SIDE_W-1:0] side, input logic [STEP_W-1:0] step);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push      <= 1'b1;
        i_edge_side <= side;
        i_edge_step <= step;
        do @(posedge i_clk); while (o_full);
        pending_pixels.push_back(project_point(side, step));
        beats_sent++;
    endtask

    // Drop push and wait until every point has come out and the pipe is quiet.
    task automatic drain_pipe();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_write(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_angles(input int sx, input int cx, input int sy, input int cy,
                                input int sz, input int cz);
        write_reg(REG_SIN_X, CFG_W'(sx));
        write_reg(REG_COS_X, CFG_W'(cx));
        write_reg(REG_SIN_Y, CFG_W'(sy));
        write_reg(REG_COS_Y, CFG_W'(cy));
        write_reg(REG_SIN_Z, CFG_W'(sz));
        write_reg(REG_COS_Z, CFG_W'(cz));
    endtask

    // Pick a step: mostly on the side, sometimes anywhere in the field.
    function automatic logic [STEP_W-1:0] pick_step();
        longint len;
        len = (shadow_len > MAX_LENGTH) ? MAX_LENGTH : shadow_len;
        if (len == 0 || $urandom_range(0, 7) == 0) return STEP_W'($urandom);
        return STEP_W'($urandom_range(0, int'(len) - 1));
    endfunction

    // Result side: pop with random gaps, honor long hold requests.
    initial begin : result_receiver
        int unsigned gap;
        t_pixel      want;
        @(posedge i_rst_n);
        forever begin
            if (pop_hold_cycles > 0) begin
                gap = pop_hold_cycles;
                pop_hold_cycles = 0;
            end else begin
                gap = burst_mode ? 0 : $urandom_range(0, 5);
            end
            @(negedge i_clk);
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
            if (pending_pixels.size() == 0) begin
                $error("unexpected result beat x=%0d y=%0d vis=%0b",
                       o_pix_x, o_pix_y, o_visible);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pix_x !== want.sx) begin
                    $error("pix_x expected %0d actual %0d", want.sx, o_pix_x);
                    error_count++;
                end
                if (o_pix_y !== want.sy) begin
                    $error("pix_y expected %0d actual %0d", want.sy, o_pix_y);
                    error_count++;
                end
                if (o_visible !== want.vis) begin
                    $error("visible expected %0b actual %0b", want.vis, o_visible);
                    error_count++;
                end
                if (!want.vis) hidden_seen++;
            end
            beats_checked++;
        end
    end

    // Default registers: all sides, steps at both ends, on and past the side.
    task automatic test_reset_defaults();
        for (int s = 0; s < 4; s++) begin
            send_point(SIDE_W'(s), 10'd0);
            send_point(SIDE_W'(s), 10'd99);
            send_point(SIDE_W'(s), 10'd1023);
        end
        send_point(SIDE_FRONT, 10'd100);
        drain_pipe();
    endtask

    // Lengths at and past the limits; the depth that sits just at the focal plane.
    task automatic test_length_extremes();
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_PLANE_LENGTH, 16'd1024);
        // left side with identity angles: step 13 sits one unit ahead of the
        // focal plane and saturates, steps 12 and below are hidden
        send_point(SIDE_LEFT, 10'd13);
        send_point(SIDE_LEFT, 10'd12);
        send_point(SIDE_LEFT, 10'd11);
        send_point(SIDE_RIGHT, 10'd13);
        drain_pipe();
        write_reg(REG_PLANE_LENGTH, 16'h07FF);
        send_point(SIDE_BACK, 10'd1023);
        send_point(SIDE_LEFT, 10'd0);
        drain_pipe();
        write_reg(REG_PLANE_LENGTH, 16'd0);
        send_point(SIDE_FRONT, 10'd0);
        send_point(SIDE_RIGHT, 10'd512);
        drain_pipe();
        write_reg(REG_PLANE_LENGTH, 16'd1);
        send_point(SIDE_BACK, 10'd0);
        drain_pipe();
    endtask

    // Quarter and half turns, plus sine and cosine at the field extremes.
    task automatic test_angle_extremes();
        write_reg(REG_PLANE_LENGTH, 16'd200);
        write_angles(0, -16384, 0, 16384, 0, 16384);     // half turn about X: behind
        send_point(SIDE_FRONT, 10'd50);
        send_point(SIDE_LEFT, 10'd150);
        drain_pipe();
        write_angles(16384, 0, 16384, 0, 16384, 0);
        send_point(SIDE_RIGHT, 10'd0);
        send_point(SIDE_BACK, 10'd199);
        drain_pipe();
        write_angles(-32768, 32767, 32767, -32768, -16384, -16384);
        send_point(SIDE_FRONT, 10'd0);
        send_point(SIDE_LEFT, 10'd1023);
        drain_pipe();
    endtask

    // Hold the receiver off long enough that the input queue fills and stalls.
    task automatic test_backpressure();
        write_angles(0, 16384, 0, 16384, 0, 16384);
        write_reg(REG_PLANE_LENGTH, 16'd64);
        pop_hold_cycles = 3 * PIPE_LAT;
        burst_mode = 1'b1;
        for (int n = 0; n < 60; n++) send_point(SIDE_W'($urandom), pick_step());
        burst_mode = 1'b0;
        drain_pipe();
    endtask

    // Random phases: new registers each phase, mostly sane, some wild.
    task automatic test_random_phases();
        int kind;
        for (int ph = 0; ph < 8; ph++) begin
            kind = $urandom_range(0, 3);
            if (kind == 0)
                write_reg(REG_PLANE_LENGTH, CFG_W'($urandom_range(0, 2047)));
            else
                write_reg(REG_PLANE_LENGTH, CFG_W'($urandom_range(1, MAX_LENGTH)));
            for (int r = REG_SIN_X; r <= REG_COS_Z; r++) begin
                if (kind == 3)
                    write_reg(IDX_W'(r), CFG_W'($urandom));
                else
                    write_reg(IDX_W'(r), CFG_W'(int'($urandom_range(0, 32768)) - 16384));
            end
            // keep some phases free of gaps on both sides
            burst_mode = (ph % 3 == 2);
            for (int n = 0; n < 40; n++) send_point(SIDE_W'($urandom), pick_step());
            burst_mode = 1'b0;
            drain_pipe();
        end
    endtask

    initial begin : main_sequence
        cycle_count     = 0;
        error_count     = 0;
        beats_sent      = 0;
        beats_checked   = 0;
        hidden_seen     = 0;
        cfg_writes      = 0;
        burst_mode      = 1'b0;
        pop_hold_cycles = 0;
        i_rst_n     = 1'b0;
        i_push      = 1'b0;
        i_pop       = 1'b0;
        i_edge_side = '0;
        i_edge_step = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        shadow_len = 100;
        shadow_sx = 0; shadow_cx = 16384;
        shadow_sy = 0; shadow_cy = 16384;
        shadow_sz = 0; shadow_cz = 16384;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_length_extremes();
        test_angle_extremes();
        test_backpressure();
        test_random_phases();

        $display("Sent %0d points, checked %0d results (%0d hidden), %0d register writes.",
                 beats_sent, beats_checked, hidden_seen, cfg_writes);
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
